FILE: rtl/kcj_pkg.sv
// ----------------------------------------------------------------------------
// kcj_pkg
// Types, constants and helpers of the cascaded scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none
package kcj_pkg;

  localparam int CHANNELS  = 5;
  localparam int GAIN_BITS = 16;
  localparam int LIMITS    = 4;

  localparam logic [2:0] CH_HEAD = 3'd0;
  localparam logic [2:0] CH_LAST = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDIFF,
    ST_CHECK,
    ST_PRED,
    ST_DIVGO,
    ST_DIV,
    ST_MULG,
    ST_MULP,
    ST_FIN
  } kcj_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] pm;
    logic [32:0] den;
  } kcj_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] k;
  } kcj_div_rsp_t;

  function automatic logic [30:0] fixed_lim(input longint whole, input int fb);
    longint v;
    v = whole <<< fb;
    if (v > 64'sh7FFF_FFFF) begin
      return 31'h7FFF_FFFF;
    end
    return v[30:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/kcj_in_if.sv
// ----------------------------------------------------------------------------
// kcj_in_if
// Sample channel: channel number, sample and noise terms.
// ----------------------------------------------------------------------------
`default_nettype none
interface kcj_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic signed [31:0] sample;
  logic [30:0]        process_noise;
  logic [30:0]        measure_noise;
  modport source (output valid, channel, sample, process_noise, measure_noise,
                  input ready);
  modport sink   (input valid, channel, sample, process_noise, measure_noise,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/kcj_out_if.sv
// ----------------------------------------------------------------------------
// kcj_out_if
// Result channel: filtered estimate and status flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface kcj_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  logic               reseeded;
  logic               count_clear;
  modport source (output valid, estimate, reseeded, count_clear, input ready);
  modport sink   (input valid, estimate, reseeded, count_clear, output ready);
endinterface
`default_nettype wire

FILE: rtl/kcj_cfg_if.sv
// ----------------------------------------------------------------------------
// kcj_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
`default_nettype none
interface kcj_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/kalman_cascade_with_jump_reset.sv
// ----------------------------------------------------------------------------
// kalman_cascade_with_jump_reset
// Five-channel scalar Kalman filter with jump and drift re-seeding.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one sample per transfer (channel, Q16.16 sample, Q and R).
//   out_ch : one result per sample (estimate, reseeded, count_clear).
//   cfg_ch : jump thresholds, index 0..3; always ready, other indexes ignored.
// A sample passes from transfer to result through difference, check,
// prediction, divider start, the restoring divider for the gain, and two
// passes through one shared 17x33 multiplier. When pm + R is zero or R is
// zero the divider answers without iterating.
// Channels 5..7 skip the datapath and return zero.
// in_ch is ready only while the sequencer is idle, from the cycle after each
// result is loaded, so a new sample is taken only once the last one is done.
// The result sits in an output register; the next sample is accepted while
// it waits. If the receiver stalls, the following sample finishes and holds
// in its last step until the output register frees.
// Reset (synchronous, active low) clears estimates, variances and drift
// history, loads the default thresholds and sets the channel 1 cascade flag.
// ----------------------------------------------------------------------------
`default_nettype none
module kalman_cascade_with_jump_reset #(
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  kcj_in_if.sink    in_ch,
  kcj_out_if.source out_ch,
  kcj_cfg_if.sink   cfg_ch
);
  import kcj_pkg::*;

  localparam logic [30:0] LIM_RST0 = fixed_lim(250, FRAC_BITS);
  localparam logic [30:0] LIM_RST1 = fixed_lim(25, FRAC_BITS);
  localparam logic [30:0] LIM_RST2 = fixed_lim(15, FRAC_BITS);
  localparam logic [30:0] LIM_RST3 = fixed_lim(10, FRAC_BITS);
  localparam logic [30:0] LIM_CH4  = fixed_lim(10, FRAC_BITS);
  localparam logic [31:0] VAR_ONE  = 32'(64'd1 << FRAC_BITS);

  kcj_state_t state_r, state_nxt;

  logic [30:0]        lim_r [LIMITS];
  logic signed [31:0] est_r [CHANNELS];
  logic [31:0]        var_r [CHANNELS];
  logic [11:0]        hist_r [3];
  logic [2:0]         casc_r, casc_nxt;

  logic [2:0]         ch_r;
  logic               bad_r;
  logic signed [31:0] z_r, last_r, x_r, x_nxt;
  logic [31:0]        p_r, p_nxt, pm_r;
  logic [30:0]        q_r, r_r;
  logic [32:0]        den_r;
  logic signed [32:0] t_r, diff_r, diff_nxt;
  logic [15:0]        k_r;
  logic signed [50:0] prod_r;
  logic               seed_r, seed_nxt, clr_r, clr_nxt;
  logic [11:0]        hist_nxt;
  logic               hist_we;

  logic               out_valid_r;
  logic signed [31:0] out_est_r;
  logic               out_seed_r, out_clr_r;

  kcj_div_req_t div_req;
  kcj_div_rsp_t div_rsp;

  logic [16:0]        mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_p;

  logic               in_xfer, out_free;
  logic [30:0]        d;
  logic signed [36:0] t37, t5, t2, d1, d2, d4;
  logic               p1, n1, p2, n2, p3, n3, jump, drift, casc_hit;
  logic [11:0]        h, nh;
  logic signed [32:0] hsum;
  logic signed [50:0] gsh;
  logic [32:0]        pm_sum;

  kcj_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.estimate    = out_est_r;
  assign out_ch.reseeded    = out_seed_r;
  assign out_ch.count_clear = out_clr_r;

  assign div_req.start = (state_r == ST_DIVGO);
  assign div_req.pm    = pm_r;
  assign div_req.den   = den_r;

  always_comb begin
    if (state_r == ST_MULG) begin
      mul_a = {1'b0, k_r};
      mul_b = diff_r;
    end else begin
      mul_a = 17'h1_0000 - {1'b0, k_r};
      mul_b = $signed({1'b0, pm_r});
    end
    mul_p = $signed({1'b0, mul_a}) * mul_b;
  end

  // jump and drift check and re-seed decision
  always_comb begin
    unique case (ch_r)
      3'd0:    d = lim_r[0];
      3'd1:    d = lim_r[1];
      3'd2:    d = lim_r[2];
      3'd3:    d = lim_r[3];
      default: d = LIM_CH4;
    endcase
    t37  = {{4{t_r[32]}}, t_r};
    t5   = (t37 <<< 2) + t37;
    t2   = t37 <<< 1;
    d1   = $signed({6'b0, d});
    d2   = d1 <<< 1;
    d4   = d1 <<< 2;
    h    = (ch_r < 3'd3) ? hist_r[ch_r[1:0]] : '0;
    p1   = (ch_r < 3'd3) && (t5 > d4);
    n1   = (ch_r < 3'd3) && (t5 < -d4);
    p2   = (ch_r < 3'd2) && (t2 > d1);
    n2   = (ch_r < 3'd2) && (t2 < -d1);
    p3   = (ch_r == CH_HEAD) && (t5 > d2);
    n3   = (ch_r == CH_HEAD) && (t5 < -d2);
    jump = (t37 > d1) || (t37 < -d1);
    drift = (p1 && h[0]) || (n1 && h[1]) || (p2 && h[2] && h[3]) ||
            (n2 && h[4] && h[5]) || (p3 && h[6] && h[7] && h[8]) ||
            (n3 && h[9] && h[10] && h[11]);
    nh = {h[10:9], n3, h[7:6], p3, h[4], n2, h[2], p2, n1, p1};
    hsum = ($signed({z_r[31], z_r}) + $signed({last_r[31], last_r})) >>> 1;
    casc_hit = (ch_r != CH_HEAD) && (ch_r < CH_LAST) && casc_r[2'(ch_r - 3'd1)];

    casc_nxt = casc_r;
    seed_nxt = 1'b0;
    clr_nxt  = 1'b0;
    x_nxt    = z_r;
    hist_we  = 1'b0;
    hist_nxt = drift ? '0 : nh;
    if (ch_r == CH_HEAD) begin
      hist_we  = 1'b1;
      seed_nxt = drift || jump;
      clr_nxt  = !drift && jump;
      x_nxt    = drift ? hsum[31:0] : z_r;
      if (seed_nxt) begin
        casc_nxt[0] = 1'b1;
      end
    end else if (ch_r == CH_LAST) begin
      seed_nxt = jump;
    end else if (casc_hit) begin
      seed_nxt = 1'b1;
      casc_nxt[2'(ch_r - 3'd1)] = 1'b0;
      if (ch_r < 3'd3) begin
        casc_nxt[ch_r[1:0]] = 1'b1;
      end
    end else begin
      hist_we  = (ch_r < 3'd3);
      seed_nxt = drift || jump;
      x_nxt    = hsum[31:0];
      if (seed_nxt && ch_r < 3'd3) begin
        casc_nxt[ch_r[1:0]] = 1'b1;
      end
    end
    if (!seed_nxt) begin
      x_nxt = last_r;
    end
    p_nxt    = seed_nxt ? VAR_ONE : p_r;
    diff_nxt = seed_nxt ? '0 : -t_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = (in_ch.channel > CH_LAST) ? ST_FIN : ST_TDIFF;
      ST_TDIFF: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_PRED;
      ST_PRED:  state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV:   if (div_rsp.done) state_nxt = ST_MULG;
      ST_MULG:  state_nxt = ST_MULP;
      ST_MULP:  state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign gsh    = prod_r >>> GAIN_BITS;
  assign pm_sum = {1'b0, p_r} + {2'b00, q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      casc_r      <= 3'b001;
      lim_r[0]    <= LIM_RST0;
      lim_r[1]    <= LIM_RST1;
      lim_r[2]    <= LIM_RST2;
      lim_r[3]    <= LIM_RST3;
      for (int i = 0; i < CHANNELS; i++) begin
        est_r[i] <= '0;
        var_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.index < 8'(LIMITS)) begin
        lim_r[cfg_ch.index[1:0]] <= cfg_ch.data;
      end
      if (state_r == ST_CHECK) begin
        casc_r <= casc_nxt;
        if (hist_we) begin
          hist_r[ch_r[1:0]] <= hist_nxt;
        end
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        if (!bad_r) begin
          est_r[ch_r] <= x_r;
          var_r[ch_r] <= prod_r[47:16];
        end
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      ch_r   <= in_ch.channel;
      bad_r  <= in_ch.channel > CH_LAST;
      z_r    <= in_ch.sample;
      q_r    <= in_ch.process_noise;
      r_r    <= in_ch.measure_noise;
      last_r <= (in_ch.channel > CH_LAST) ? '0 : est_r[in_ch.channel];
      p_r    <= (in_ch.channel > CH_LAST) ? '0 : var_r[in_ch.channel];
      seed_r <= 1'b0;
      clr_r  <= 1'b0;
      x_r    <= '0;
    end
    if (state_r == ST_TDIFF) begin
      t_r <= $signed({last_r[31], last_r}) - $signed({z_r[31], z_r});
    end
    if (state_r == ST_CHECK) begin
      seed_r <= seed_nxt;
      clr_r  <= clr_nxt;
      x_r    <= x_nxt;
      p_r    <= p_nxt;
      diff_r <= diff_nxt;
    end
    if (state_r == ST_PRED) begin
      pm_r  <= pm_sum[32] ? 32'hFFFF_FFFF : pm_sum[31:0];
      den_r <= (pm_sum[32] ? 33'h0_FFFF_FFFF : pm_sum) + {2'b00, r_r};
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      k_r <= div_rsp.k;
    end
    if (state_r == ST_MULG) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_MULP) begin
      x_r    <= x_r + gsh[31:0];
      prod_r <= mul_p;
    end
    if (state_r == ST_FIN && out_free) begin
      out_est_r  <= x_r;
      out_seed_r <= seed_r;
      out_clr_r  <= clr_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kcj_div.sv
// ----------------------------------------------------------------------------
// kcj_div
// Restoring divider for the Q0.16 gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module kcj_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire kcj_pkg::kcj_div_req_t req,
  output kcj_pkg::kcj_div_rsp_t      rsp
);
  import kcj_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [33:0]          rem_r, rem_nxt;
  logic [32:0]          den_r, den_nxt;
  logic [GAIN_BITS-1:0] q_r, q_nxt;
  logic [33:0]          rem2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    rem2     = {rem_r[32:0], 1'b0};
    if (req.start) begin
      den_nxt = req.den;
      rem_nxt = {2'b00, req.pm};
      if (req.den == '0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else if ({1'b0, req.pm} == req.den) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        q_nxt    = '0;
        busy_nxt = 1'b1;
        cnt_nxt  = 5'(GAIN_BITS);
      end
    end else if (busy_r) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_nxt = rem2 - {1'b0, den_r};
        q_nxt   = {q_r[GAIN_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem2;
        q_nxt   = {q_r[GAIN_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.k    = q_r;

endmodule
`default_nettype wire

FILE: rtl/kcj_checker.sv
// ----------------------------------------------------------------------------
// kcj_checker
// Port-level checks of the cascaded Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module kcj_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_estimate,
  input wire logic        out_reseeded,
  input wire logic        out_count_clear
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_estimate))
    else $error("stalled result changed");

  a_rise_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  a_clear_implies_seed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count_clear |-> out_reseeded)
    else $error("count_clear without reseed");

endmodule

bind kalman_cascade_with_jump_reset kcj_checker u_kcj_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_estimate    (out_ch.estimate),
  .out_reseeded    (out_ch.reseeded),
  .out_count_clear (out_ch.count_clear)
);
`default_nettype wire
